>>> rtl/assert_macros.svh
// Assertion macros shared by the timer bank RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define MCST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("timer bank assertion failed");
`define MCST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("timer bank invariant failed");
`else
`define MCST_ASSERT(lbl, prop)
`define MCST_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/mcst_pkg.sv
// Package for the soft timer bank: sizes, operation, status and run codes,
// and the store request struct. No dependencies.
package mcst_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int TMR_W = 32;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_RESET   = 3'd4;
  localparam logic [2:0] OP_SERVICE = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PARAM = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] RS_STOPPED = 2'd0;
  localparam logic [1:0] RS_RUNNING = 2'd1;
  localparam logic [1:0] RS_EXPIRED = 2'd2;

  typedef struct packed {
    logic             per_we;
    logic             cnt_we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [TMR_W:0]   per_wdata;  // {auto_reload, period}
    logic [TMR_W-1:0] cnt_wdata;
  } store_req_t;

  typedef struct packed {
    logic [TMR_W-1:0] next;
    logic             zero;
  } dec_res_t;

endpackage

>>> rtl/mcst_dec_unit.sv
// Shared countdown unit: saturating decrement and zero detect.
// Depends on mcst_pkg.
module mcst_dec_unit (
  input  logic [mcst_pkg::TMR_W-1:0] count_i,
  output mcst_pkg::dec_res_t         res_o
);
  import mcst_pkg::*;

  always_comb begin
    res_o.next = (count_i == '0) ? '0 : count_i - TMR_W'(1);
    res_o.zero = (res_o.next == '0);
  end

endmodule

>>> rtl/mcst_store.sv
// Period/mode and remaining-count memories, one write and one registered
// read port each, sharing addresses. Depends on mcst_pkg.
module mcst_store (
  input  logic                       clk_i,
  input  mcst_pkg::store_req_t       req_i,
  output logic [mcst_pkg::TMR_W:0]   per_rdata_o,
  output logic [mcst_pkg::TMR_W-1:0] cnt_rdata_o
);
  import mcst_pkg::*;

  logic [TMR_W:0]   per_mem [NUM_TIMERS];
  logic [TMR_W-1:0] cnt_mem [NUM_TIMERS];

  always_ff @(posedge clk_i) begin
    if (req_i.per_we) begin
      per_mem[req_i.waddr] <= req_i.per_wdata;
    end
    per_rdata_o <= per_mem[req_i.raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem[req_i.waddr] <= req_i.cnt_wdata;
    end
    cnt_rdata_o <= cnt_mem[req_i.raddr];
  end

endmodule

>>> rtl/multi_channel_soft_timer_bank.sv
// Bank of countdown timers (one-shot or auto-reload) driven by a command
// stream; one result per command, or one per fired timer on service.
// Depends on mcst_pkg, mcst_store, mcst_dec_unit and assert_macros.svh.
//
// A count memory with one read and one write port is walked one slot per
// cycle by one shared decrement unit on a tick. Service scans one slot per
// cycle and sends each expired slot through a fire state, which waits for
// a free output register. Create and stop pass through dispatch and
// response; start and reset also pass through a reload state; each may wait
// on m_axis_tready. The input is ready only between commands; a result held
// in the output register does not block the next command from entering.
module multi_channel_soft_timer_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], timer_index[6:3], period[38:7], auto_reload[39]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], slot[5:2], fired[6], tick_expired[7]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  import mcst_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_RELOAD   = 3'd2;
  localparam logic [2:0] S_TICK     = 3'd3;
  localparam logic [2:0] S_SVC_SCAN = 3'd4;
  localparam logic [2:0] S_SVC_FIRE = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             st_v_q, st_v_d;
  logic [IDX_W-1:0] st_idx_q, st_idx_d;
  logic             any_q, any_d;
  logic             fired_any_q, fired_any_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [3:0]       res_slot_q, res_slot_d;
  logic             res_any_q, res_any_d;

  logic [2:0]       op_q;
  logic [3:0]       idx_q;
  logic [TMR_W-1:0] per_q;
  logic             mode_q;

  logic [1:0]       run_q [NUM_TIMERS];
  logic             rs_we;
  logic [IDX_W-1:0] rs_waddr;
  logic [1:0]       rs_wdata;

  logic             m_valid_q, m_valid_d;
  logic [7:0]       m_data_q, m_data_d;
  logic             m_last_q, m_last_d;
  logic             out_free;

  store_req_t       req;
  logic [TMR_W:0]   per_rdata;
  logic [TMR_W-1:0] cnt_rdata;
  dec_res_t         dec;

  logic [NUM_TIMERS-1:0] expired;
  logic [NUM_TIMERS-1:0] later;
  logic [IDX_W-1:0]      idx_w;
  logic [IDX_W-1:0]      ptr_w;
  logic                  idx_ok;
  logic                  bank_full;
  logic                  accept;

  mcst_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .per_rdata_o (per_rdata),
    .cnt_rdata_o (cnt_rdata)
  );

  mcst_dec_unit u_dec (
    .count_i (cnt_rdata),
    .res_o   (dec)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  assign idx_w     = IDX_W'(idx_q);
  assign ptr_w     = ptr_q[IDX_W-1:0];
  assign idx_ok    = CMP_W'(idx_q) < CMP_W'(used_q);
  assign bank_full = used_q >= CNT_W'(NUM_TIMERS);

  always_comb begin
    for (int j = 0; j < NUM_TIMERS; j++) begin
      expired[j] = (run_q[j] == RS_EXPIRED);
      later[j]   = expired[j] && (CNT_W'(j) > ptr_q);
    end
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    used_d       = used_q;
    st_v_d       = 1'b0;
    st_idx_d     = st_idx_q;
    any_d        = any_q;
    fired_any_d  = fired_any_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_any_d    = res_any_q;
    rs_we        = 1'b0;
    rs_waddr     = idx_w;
    rs_wdata     = RS_STOPPED;
    req.per_we    = 1'b0;
    req.cnt_we    = 1'b0;
    req.waddr     = idx_w;
    req.raddr     = idx_w;
    req.per_wdata = {mode_q, per_q};
    req.cnt_wdata = per_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_status_d = ST_OK;
        res_slot_d   = '0;
        res_any_d    = 1'b0;
        state_d      = S_RESP;
        unique case (op_q) inside
          OP_TICK: begin
            ptr_d   = '0;
            any_d   = 1'b0;
            state_d = S_TICK;
          end
          OP_CREATE: begin
            if (per_q == '0) begin
              res_status_d = ST_PARAM;
            end else if (bank_full) begin
              res_status_d = ST_FULL;
            end else begin
              req.per_we = 1'b1;
              req.cnt_we = 1'b1;
              req.waddr  = used_q[IDX_W-1:0];
              rs_we      = 1'b1;
              rs_waddr   = used_q[IDX_W-1:0];
              rs_wdata   = RS_STOPPED;
              res_slot_d = 4'(used_q);
              used_d     = used_q + CNT_W'(1);
            end
          end
          OP_START, OP_RESET: begin
            if (idx_ok) begin
              state_d = S_RELOAD;
            end else begin
              res_status_d = ST_PARAM;
            end
          end
          OP_STOP: begin
            if (idx_ok) begin
              rs_we    = 1'b1;
              rs_wdata = RS_STOPPED;
            end else begin
              res_status_d = ST_PARAM;
            end
          end
          OP_SERVICE: begin
            ptr_d       = '0;
            fired_any_d = 1'b0;
            state_d     = S_SVC_SCAN;
          end
          default: begin
            res_status_d = ST_PARAM;
          end
        endcase
      end
      S_RELOAD: begin
        req.cnt_we    = 1'b1;
        req.cnt_wdata = per_rdata[TMR_W-1:0];
        rs_we         = 1'b1;
        rs_wdata      = RS_RUNNING;
        state_d       = S_RESP;
      end
      S_TICK: begin
        req.raddr = ptr_w;
        if (ptr_q < used_q) begin
          ptr_d    = ptr_q + CNT_W'(1);
          st_v_d   = 1'b1;
          st_idx_d = ptr_w;
        end
        if (st_v_q && (run_q[st_idx_q] == RS_RUNNING)) begin
          req.cnt_we    = 1'b1;
          req.waddr     = st_idx_q;
          req.cnt_wdata = dec.next;
          if (dec.zero) begin
            rs_we    = 1'b1;
            rs_waddr = st_idx_q;
            rs_wdata = RS_EXPIRED;
            any_d    = 1'b1;
          end
        end
        if ((ptr_q >= used_q) && !st_v_q) begin
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_any_d    = any_q;
          state_d      = S_RESP;
        end
      end
      S_SVC_SCAN: begin
        req.raddr = ptr_w;
        if (ptr_q >= used_q) begin
          if (fired_any_q) begin
            state_d = S_IDLE;
          end else begin
            res_status_d = ST_OK;
            res_slot_d   = '0;
            res_any_d    = 1'b0;
            state_d      = S_RESP;
          end
        end else if (expired[ptr_w]) begin
          state_d = S_SVC_FIRE;
        end else begin
          ptr_d = ptr_q + CNT_W'(1);
        end
      end
      S_SVC_FIRE: begin
        req.raddr = ptr_w;
        req.waddr = ptr_w;
        rs_waddr  = ptr_w;
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, 1'b1, 4'(ptr_q), ST_OK};
          m_last_d  = ~|later;
          rs_we     = 1'b1;
          if (per_rdata[TMR_W]) begin
            req.cnt_we    = 1'b1;
            req.cnt_wdata = per_rdata[TMR_W-1:0];
            rs_wdata      = RS_RUNNING;
          end else begin
            rs_wdata = RS_STOPPED;
          end
          fired_any_d = 1'b1;
          ptr_d       = ptr_q + CNT_W'(1);
          state_d     = S_SVC_SCAN;
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_any_q, 1'b0, res_slot_q, res_status_q};
          m_last_d  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      used_q      <= '0;
      st_v_q      <= 1'b0;
      any_q       <= 1'b0;
      fired_any_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      used_q      <= used_d;
      st_v_q      <= st_v_d;
      any_q       <= any_d;
      fired_any_q <= fired_any_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_TIMERS; j++) begin
        run_q[j] <= RS_STOPPED;
      end
    end else if (rs_we) begin
      run_q[rs_waddr] <= rs_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    st_idx_q     <= st_idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_any_q    <= res_any_d;
    m_data_q     <= m_data_d;
    m_last_q     <= m_last_d;
    if (accept) begin
      op_q   <= s_axis_tdata[2:0];
      idx_q  <= s_axis_tdata[6:3];
      per_q  <= s_axis_tdata[38:7];
      mode_q <= s_axis_tdata[39];
    end
  end

`include "assert_macros.svh"

  `MCST_ASSERT(a_used_bound, used_q <= CNT_W'(NUM_TIMERS))
  `MCST_ASSERT(a_fire_slot_created, (m_axis_tvalid && m_axis_tdata[6]) |-> (CMP_W'(m_axis_tdata[5:2]) < CMP_W'(used_q)))
  `MCST_ASSERT(a_fire_is_expired, (state_q == S_SVC_FIRE) |-> expired[ptr_w])
  `MCST_ASSERT(a_idle_no_write, (state_q == S_IDLE) |-> (!req.per_we && !req.cnt_we && !rs_we))

endmodule
